// ===== rtl/core/stks_pkg.sv =====
// Shared constants and helpers for the sorted table key search block.
package stks_pkg;

	// Fixed field widths of the transaction payloads
	localparam int IDX_W = 10;
	localparam int VAL_W = 32;
	localparam int CNT_W = 11;

	// Defaults for the top level parameters
	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_ENTRY_WIDTH = 32;

	// Configuration port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = '0;

	// Request function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Stored bits per entry: the entry width, capped at the field width
	function automatic int entry_bits(input int ew);
		return (ew < VAL_W) ? ew : VAL_W;
	endfunction

endpackage

// ===== rtl/core/stks_if.sv =====
// Request and response channel interfaces for the sorted table key search block.
interface stks_req_if;
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic [stks_pkg::IDX_W-1:0] entry_index;
	logic signed [stks_pkg::VAL_W-1:0] entry_value;
	logic signed [stks_pkg::VAL_W-1:0] search_key;

	modport source (output valid, func, entry_index, entry_value, search_key, input ready);
	modport sink (input valid, func, entry_index, entry_value, search_key, output ready);
endinterface

interface stks_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [stks_pkg::IDX_W-1:0] first_match_res;
	logic [stks_pkg::CNT_W-1:0] match_count;

	modport source (output valid, found, first_match_res, match_count, input ready);
	modport sink (input valid, found, first_match_res, match_count, output ready);
endinterface

// ===== rtl/core/stks_cfg.sv =====
// APB register block holding the searched entry count.
module stks_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [stks_pkg::PADDR_W-1:0] paddr,
	input  logic [stks_pkg::PDATA_W-1:0] pwdata,
	output logic [stks_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output logic [stks_pkg::CNT_W-1:0]   entry_count
);

	logic [stks_pkg::REG_IDX_W-1:0] reg_idx;
	logic [stks_pkg::CNT_W-1:0]     entry_count_q;
	logic                           wr_fire;

	assign pready  = 1'b1;
	assign reg_idx = paddr[stks_pkg::PADDR_W-1:2];
	assign wr_fire = psel && penable && pwrite && pready;

	// Update the register on a completed write transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (wr_fire && (reg_idx == stks_pkg::REG_ENTRY_COUNT)) begin
			entry_count_q <= pwdata[stks_pkg::CNT_W-1:0];
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			stks_pkg::REG_ENTRY_COUNT: prdata = stks_pkg::PDATA_W'(entry_count_q);
			default:                   prdata = '0;
		endcase
	end

	assign entry_count = entry_count_q;

endmodule

// ===== rtl/core/stks_table.sv =====
// Entry memory: one write port and two registered read ports.
module stks_table #(
	parameter int TABLE_DEPTH = stks_pkg::DEF_TABLE_DEPTH,
	parameter int ENTRY_WIDTH = stks_pkg::DEF_ENTRY_WIDTH,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int SW = stks_pkg::entry_bits(ENTRY_WIDTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [SW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_l,
	input  logic [AW-1:0] rd_addr_u,
	output logic [SW-1:0] rd_data_l,
	output logic [SW-1:0] rd_data_u
);

	logic [SW-1:0] table_q [TABLE_DEPTH];
	logic [SW-1:0] rd_l_q;
	logic [SW-1:0] rd_u_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_addr] <= wr_data;
		end
	end

	// Two read ports, one for each bisection
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_l_q <= table_q[rd_addr_l];
			rd_u_q <= table_q[rd_addr_u];
		end
	end

	assign rd_data_l = rd_l_q;
	assign rd_data_u = rd_u_q;

endmodule

// ===== rtl/core/stks_ctrl.sv =====
// Request decode, lower and upper bound bisection sequencer and response register.
module stks_ctrl #(
	parameter int TABLE_DEPTH = stks_pkg::DEF_TABLE_DEPTH,
	parameter int ENTRY_WIDTH = stks_pkg::DEF_ENTRY_WIDTH,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int BW = $clog2(TABLE_DEPTH + 1),
	localparam int SW = stks_pkg::entry_bits(ENTRY_WIDTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	stks_req_if.sink                   req,
	stks_rsp_if.source                 rsp,
	input  logic [stks_pkg::CNT_W-1:0] entry_count,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [SW-1:0]              wr_data,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr_l,
	output logic [AW-1:0]              rd_addr_u,
	input  logic [SW-1:0]              rd_data_l,
	input  logic [SW-1:0]              rd_data_u
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_CMP   = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [BW-1:0]              lo_l_q, hi_l_q, lo_u_q, hi_u_q;
	logic [BW-1:0]              mid_l_q, mid_u_q;
	logic [SW-1:0]              key_q;
	logic                       rsp_valid_q;
	logic                       found_q;
	logic [stks_pkg::IDX_W-1:0] first_q;
	logic [stks_pkg::CNT_W-1:0] count_q;

	logic                       req_fire;
	logic                       start;
	logic [BW-1:0]              n_sat;
	logic                       act_l, act_u;
	logic [BW-1:0]              mid_l, mid_u;
	logic                       go_l, go_u;
	logic                       hit;
	logic [BW-1:0]              count;
	logic                       load;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign start     = req_fire && (req.func == stks_pkg::FUNC_QUERY);

	// Table writes go straight to the memory; out-of-range positions are dropped
	assign wr_en   = req_fire && (req.func == stks_pkg::FUNC_WRITE)
	                 && (32'(req.entry_index) < 32'(TABLE_DEPTH));
	assign wr_addr = AW'(req.entry_index);
	assign wr_data = req.entry_value[SW-1:0];

	// Clamp the searched length to the table depth
	assign n_sat = (32'(entry_count) > 32'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH)
	                                                       : BW'(entry_count);

	// Probe positions for both bisections
	assign act_l = lo_l_q < hi_l_q;
	assign act_u = lo_u_q < hi_u_q;
	assign mid_l = lo_l_q + ((hi_l_q - lo_l_q) >> 1);
	assign mid_u = lo_u_q + ((hi_u_q - lo_u_q) >> 1);

	assign rd_en     = (state_q == ST_ISSUE) && (act_l || act_u);
	assign rd_addr_l = mid_l[AW-1:0];
	assign rd_addr_u = mid_u[AW-1:0];

	// Lower bound moves right past entries below the key, upper bound past those not above
	assign go_l = $signed(rd_data_l) <  $signed(key_q);
	assign go_u = $signed(rd_data_u) <= $signed(key_q);

	// Result of the finished searches
	assign hit   = hi_u_q > lo_l_q;
	assign count = hit ? (hi_u_q - lo_l_q) : '0;
	assign load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Sequencer and search bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lo_l_q  <= '0;
			hi_l_q  <= '0;
			lo_u_q  <= '0;
			hi_u_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						lo_l_q  <= '0;
						hi_l_q  <= n_sat;
						lo_u_q  <= '0;
						hi_u_q  <= n_sat;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (act_l || act_u) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CMP: begin
					if (act_l) begin
						if (go_l) begin
							lo_l_q <= mid_l_q + BW'(1);
						end else begin
							hi_l_q <= mid_l_q;
						end
					end
					if (act_u) begin
						if (go_u) begin
							lo_u_q <= mid_u_q + BW'(1);
						end else begin
							hi_u_q <= mid_u_q;
						end
					end
					state_q <= ST_ISSUE;
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the key and the probe positions that match the data in flight
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= req.search_key[SW-1:0];
		end
		if (state_q == ST_ISSUE) begin
			mid_l_q <= mid_l;
			mid_u_q <= mid_u;
		end
	end

	// Response register: a finished result waits here while the next request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			found_q <= hit;
			first_q <= hit ? stks_pkg::IDX_W'(lo_l_q) : '0;
			count_q <= stks_pkg::CNT_W'(count);
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.found           = found_q;
	assign rsp.first_match_res = first_q;
	assign rsp.match_count     = count_q;

endmodule

// ===== rtl/core/sorted_table_key_search.sv =====
// Top level of the sorted table key search block.
//
//   channel  direction  handshake            payload
//   req      in         valid/ready          func, entry_index, entry_value, search_key
//   rsp      out        valid/ready          found, first_match_res, match_count
//   apb      in         psel/penable/pready  entry_count at byte address 0
//
// A table write goes straight to the memory. A query runs up to P probes per bisection,
// P being ceil(log2(n+1)) for n searched entries (11 for 1024): each probe is a
// memory read followed by a compare, and the two bisections run side by side, one on
// each read port of the table.
// Reset clears the control state and entry_count; the table contents stay undefined.
// A query result waits in the response register while the next request is accepted.
module sorted_table_key_search #(
	parameter int TABLE_DEPTH = stks_pkg::DEF_TABLE_DEPTH,
	parameter int ENTRY_WIDTH = stks_pkg::DEF_ENTRY_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	stks_req_if.sink                     req,
	stks_rsp_if.source                   rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [stks_pkg::PADDR_W-1:0] paddr,
	input  logic [stks_pkg::PDATA_W-1:0] pwdata,
	output logic [stks_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int SW = stks_pkg::entry_bits(ENTRY_WIDTH);

	logic [stks_pkg::CNT_W-1:0] entry_count;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [SW-1:0]              wr_data;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr_l, rd_addr_u;
	logic [SW-1:0]              rd_data_l, rd_data_u;

	// Configuration registers
	stks_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.entry_count (entry_count)
	);

	// Entry memory
	stks_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_table (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_l (rd_addr_l),
		.rd_addr_u (rd_addr_u),
		.rd_data_l (rd_data_l),
		.rd_data_u (rd_data_u)
	);

	// Search sequencer
	stks_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.entry_count (entry_count),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr_l   (rd_addr_l),
		.rd_addr_u   (rd_addr_u),
		.rd_data_l   (rd_data_l),
		.rd_data_u   (rd_data_u)
	);

endmodule

// ===== dv/tb_sorted_table_key_search.sv =====
// Testbench for the sorted table key search block: predicted equal-range lookups.
`timescale 1ns / 100ps

module tb_sorted_table_key_search;

	localparam int TABLE_DEPTH  = stks_pkg::DEF_TABLE_DEPTH;
	localparam int DRAIN_CYCLES = 64;
	localparam int ITEM_TARGET  = 1870;
	localparam int MAX_REPORTS  = 10;
	localparam longint TIMEOUT_NS = 4_000_000;

	localparam logic [stks_pkg::PADDR_W-1:0] ENTRY_COUNT_ADDR =
		{stks_pkg::REG_ENTRY_COUNT, 2'b00};
	localparam logic signed [stks_pkg::VAL_W-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [stks_pkg::VAL_W-1:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic                       found;
		logic [stks_pkg::IDX_W-1:0] first;
		logic [stks_pkg::CNT_W-1:0] count;
	} lookup_t;

	bit clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [stks_pkg::PADDR_W-1:0] paddr;
	logic [stks_pkg::PDATA_W-1:0] pwdata, prdata;

	stks_req_if req_ch();
	stks_rsp_if rsp_ch();

	sorted_table_key_search u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the table and the count register
	logic signed [stks_pkg::VAL_W-1:0] model_table [TABLE_DEPTH];
	logic [stks_pkg::CNT_W-1:0]        model_count;
	lookup_t                           lookup_expect_q [$];

	int src_idle_pct;
	int sink_stall_pct;
	int items_sent;
	int mismatch_count;

	initial begin
		forever #1 clk = ~clk;
	end

	// Abandon a hung run
	initial begin
		#(TIMEOUT_NS);
		$display("tb_sorted_table_key_search failed");
		$finish;
	end

	// Stall the response side at random
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic flag_mismatch(input string what, input longint exp_v, input longint act_v);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch on %s: expected %0d, actual %0d", what, exp_v, act_v);
	endtask

	// First searched index whose entry is >= key, or > key for the upper bound
	function automatic int unsigned bisect_table(input int unsigned n,
			input logic signed [stks_pkg::VAL_W-1:0] key, input bit upper);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (upper ? (model_table[mid] <= key) : (model_table[mid] < key))
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	function automatic int unsigned searched_count();
		return (model_count > TABLE_DEPTH) ? TABLE_DEPTH : model_count;
	endfunction

	function automatic lookup_t predict_lookup(input logic signed [stks_pkg::VAL_W-1:0] key);
		int unsigned n, lo_b, hi_b;
		lookup_t r;
		n = searched_count();
		lo_b = bisect_table(n, key, 1'b0);
		hi_b = bisect_table(n, key, 1'b1);
		r.found = hi_b > lo_b;
		r.first = r.found ? lo_b[stks_pkg::IDX_W-1:0] : '0;
		r.count = r.found ? stks_pkg::CNT_W'(hi_b - lo_b) : '0;
		return r;
	endfunction

	// Keys present in the searched range half the time, plus neighbours, extremes and random keys
	function automatic logic signed [stks_pkg::VAL_W-1:0] pick_key();
		int unsigned n;
		logic signed [stks_pkg::VAL_W-1:0] probe;
		n = searched_count();
		probe = (n != 0) ? model_table[$urandom_range(n - 1)] : $signed($urandom);
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return probe;
			5: return probe + 1;
			6: return probe - 1;
			7: return KEY_MIN;
			8: return KEY_MAX;
			default: return $signed($urandom);
		endcase
	endfunction

	function automatic void set_idle_phase(input int phase);
		case (phase)
			0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
			default: begin src_idle_pct = 22; sink_stall_pct = 22; end
		endcase
	endfunction

	// Offer one request transaction and record what it should cause
	task automatic send_request(input logic func, input logic [stks_pkg::IDX_W-1:0] idx,
			input logic signed [stks_pkg::VAL_W-1:0] value,
			input logic signed [stks_pkg::VAL_W-1:0] key);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.func        <= func;
		req_ch.entry_index <= idx;
		req_ch.entry_value <= value;
		req_ch.search_key  <= key;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
		if (func == stks_pkg::FUNC_WRITE)
			model_table[idx] = value;
		else
			lookup_expect_q = {lookup_expect_q, predict_lookup(key)};
	endtask

	task automatic write_entry(input logic [stks_pkg::IDX_W-1:0] idx,
			input logic signed [stks_pkg::VAL_W-1:0] value);
		send_request(stks_pkg::FUNC_WRITE, idx, value, $signed($urandom));
	endtask

	task automatic run_query(input logic signed [stks_pkg::VAL_W-1:0] key);
		send_request(stks_pkg::FUNC_QUERY, stks_pkg::IDX_W'($urandom), $signed($urandom), key);
	endtask

	// Drop valid, let every result arrive, then let the block settle
	task automatic wait_for_results();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (lookup_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic is_write, input logic [stks_pkg::PDATA_W-1:0] wdata,
			output logic [stks_pkg::PDATA_W-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= ENTRY_COUNT_ADDR;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Program entry_count while idle and read it back
	task automatic set_entry_count(input logic [stks_pkg::CNT_W-1:0] count);
		logic [stks_pkg::PDATA_W-1:0] rd;
		wait_for_results();
		apb_access(1'b1, stks_pkg::PDATA_W'(count), rd);
		model_count = count;
		apb_access(1'b0, '0, rd);
		if (rd !== stks_pkg::PDATA_W'(count))
			flag_mismatch("entry_count readback", count, rd);
	endtask

	// Fill entries 0..n-1 in ascending order, with runs of equal values
	task automatic load_ascending(input int n, input int unsigned stepmax, input bit full_span);
		longint acc;
		acc = full_span ? longint'(KEY_MIN) : longint'($signed($urandom));
		for (int i = 0; i < n; i++) begin
			if (full_span && i == n - 1)
				acc = longint'(KEY_MAX);
			write_entry(i[stks_pkg::IDX_W-1:0], stks_pkg::VAL_W'(acc));
			if ($urandom_range(9) >= 3)
				acc += $urandom_range(stepmax, 1);
			if (acc > longint'(KEY_MAX))
				acc = longint'(KEY_MAX);
		end
	endtask

	// Compare each response transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		lookup_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (lookup_expect_q.size() == 0) begin
				flag_mismatch("response with nothing outstanding", 0, 1);
			end else begin
				want = lookup_expect_q.pop_front();
				if (rsp_ch.found !== want.found)
					flag_mismatch("found", want.found, rsp_ch.found);
				if (rsp_ch.first_match_res !== want.first)
					flag_mismatch("first_match_res", want.first, rsp_ch.first_match_res);
				if (rsp_ch.match_count !== want.count)
					flag_mismatch("match_count", want.count, rsp_ch.match_count);
			end
		end
	end

	// Empty table, single entry, duplicates, gaps and the value extremes
	task automatic test_directed_extremes();
		logic signed [stks_pkg::VAL_W-1:0] vals [8];
		vals = '{KEY_MIN, KEY_MIN, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd5, KEY_MAX};
		set_idle_phase(0);
		run_query(32'sd0);
		for (int i = 0; i < 8; i++)
			write_entry(i[stks_pkg::IDX_W-1:0], vals[i]);
		set_entry_count(stks_pkg::CNT_W'(1));
		run_query(KEY_MIN);
		run_query(KEY_MAX);
		set_entry_count(stks_pkg::CNT_W'(8));
		run_query(KEY_MIN);
		run_query(-32'sd1);
		run_query(32'sd0);
		run_query(32'sd5);
		run_query(KEY_MAX);
		run_query(32'sd3);
		run_query(-32'sd2);
	endtask

	// Whole table, then a count beyond the depth that must saturate
	task automatic test_full_table();
		set_idle_phase(0);
		load_ascending(TABLE_DEPTH, 32'd1 << 23, 1'b1);
		set_entry_count(stks_pkg::CNT_W'(TABLE_DEPTH));
		set_idle_phase(1);
		repeat (40) run_query(pick_key());
		set_entry_count({stks_pkg::CNT_W{1'b1}});
		set_idle_phase(2);
		repeat (40) run_query(pick_key());
	endtask

	// Random contents with repeats: the bisections run as if sorted
	task automatic test_unsorted_table();
		logic signed [stks_pkg::VAL_W-1:0] value;
		set_idle_phase(3);
		value = $signed($urandom);
		for (int i = 0; i < 40; i++) begin
			if (i == 0 || $urandom_range(3) != 0)
				value = $signed($urandom);
			write_entry(i[stks_pkg::IDX_W-1:0], value);
		end
		set_entry_count(stks_pkg::CNT_W'(40));
		repeat (40) run_query(pick_key());
	endtask

	// Load a sorted prefix, set the count, query it; stray writes as noise
	task automatic test_random_rounds();
		int round, n, nq, pick;
		int unsigned stepmax;
		round = 0;
		while (items_sent < ITEM_TARGET) begin
			set_idle_phase(round % 4);
			pick = $urandom_range(19);
			if (pick == 0)
				n = 0;
			else if (pick < 14)
				n = $urandom_range(16, 1);
			else if (pick < 19)
				n = $urandom_range(128, 17);
			else
				n = $urandom_range(400, 200);
			case ($urandom_range(3))
				0: stepmax = 1;
				1: stepmax = 4;
				2: stepmax = 1000;
				default: stepmax = 32'd1 << 24;
			endcase
			load_ascending(n, stepmax, 1'b0);
			set_entry_count(($urandom_range(99) < 85) ? stks_pkg::CNT_W'(n)
			                                          : stks_pkg::CNT_W'($urandom_range(2047)));
			nq = $urandom_range(24, 8);
			for (int q = 0; q < nq; q++) begin
				if ($urandom_range(99) < 12) begin
					write_entry(stks_pkg::IDX_W'($urandom), $signed($urandom));
				end else begin
					// hold off until the pipeline is empty now and then
					if ($urandom_range(99) < 5)
						wait_for_results();
					run_query(pick_key());
				end
			end
			round++;
		end
	endtask

	initial begin
		req_ch.valid       <= 1'b0;
		req_ch.func        <= stks_pkg::FUNC_WRITE;
		req_ch.entry_index <= '0;
		req_ch.entry_value <= '0;
		req_ch.search_key  <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		arst_n  <= 1'b0;
		model_count = '0;
		set_idle_phase(0);
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_extremes();
		test_full_table();
		test_unsorted_table();
		test_random_rounds();
		wait_for_results();

		if (mismatch_count == 0 && lookup_expect_q.size() == 0)
			$display("tb_sorted_table_key_search passed");
		else
			$display("tb_sorted_table_key_search failed");
		$finish;
	end

endmodule
